>>> rtl/sfca_pkg.sv
// Shared types and constants for the sensor frame converter.
package sfca_pkg;

    localparam int LANES   = 9;
    localparam int READ_W  = 48;
    localparam int IDX_W   = 4;
    localparam int CODE_W  = 5;
    localparam int MAG_W   = 28;

    localparam logic [2:0] ACT_TEMP   = 3'd0;
    localparam logic [2:0] ACT_HUM    = 3'd1;
    localparam logic [2:0] ACT_PRES   = 3'd2;
    localparam logic [2:0] ACT_MOVE   = 3'd3;
    localparam logic [2:0] ACT_BRIGHT = 3'd4;

    localparam logic [7:0] LEN_TEMP   = 8'd4;
    localparam logic [7:0] LEN_HUM    = 8'd4;
    localparam logic [7:0] LEN_PRES   = 8'd6;
    localparam logic [7:0] LEN_MOVE   = 8'd18;
    localparam logic [7:0] LEN_BRIGHT = 8'd2;

    // present mask bit positions
    localparam int BIT_TEMP   = 0;
    localparam int BIT_HUM    = 1;
    localparam int BIT_MOVE   = 2;
    localparam int BIT_PRES   = 3;
    localparam int BIT_BRIGHT = 4;

    // highest quantity code of each group
    localparam logic [CODE_W-1:0] CODE_HEADER   = 5'd0;
    localparam logic [CODE_W-1:0] CODE_TEMP_END = 5'd2;
    localparam logic [CODE_W-1:0] CODE_HUM_END  = 5'd4;
    localparam logic [CODE_W-1:0] CODE_PRES_END = 5'd6;
    localparam logic [CODE_W-1:0] CODE_MOVE_END = 5'd15;
    localparam logic [CODE_W-1:0] CODE_BRIGHT   = 5'd16;

    localparam logic CFG_REQUIRED = 1'b0;
    localparam logic CFG_ACCEL    = 1'b1;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   idx;
        logic [READ_W-1:0]  value;
    } t_wr;

    // divisor a lane applies after its numerator is scaled
    typedef enum logic [1:0] {
        DIV_ONE = 2'd0,
        DIV_25  = 2'd1,
        DIV_131 = 2'd2
    } t_div;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CONV  = 4'b0010,
        S_CHECK = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

endpackage

>>> rtl/sfca_lane.sv
// One conversion lane: pass through or divide by 25 or 131 via reciprocal multiply of four partial products, sign.
module sfca_lane
    import sfca_pkg::*;
#(
    parameter int NUM_W = 44
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_neg,
    input  logic [NUM_W-1:0]   i_num,
    input  t_div               i_div,
    output logic               o_busy,
    output logic [READ_W-1:0]  o_q
);

    // floor(n / d) equals (n * ceil(2^SHIFT / d)) >> SHIFT for n below 2^NUM_W and d below 256
    localparam int SHIFT = NUM_W + 8;
    localparam int HALF  = (NUM_W + 5) / 2;
    localparam int ACC_W = 4 * HALF;
    localparam logic [2*HALF-1:0] RECIP_25  =
        (2*HALF)'(((64'd1 << SHIFT) + 64'd24) / 64'd25);
    localparam logic [2*HALF-1:0] RECIP_131 =
        (2*HALF)'(((64'd1 << SHIFT) + 64'd130) / 64'd131);

    logic               r_busy;
    logic [1:0]         r_step;
    logic [NUM_W-1:0]   r_num;
    t_div               r_div;
    logic               r_neg;
    logic [ACC_W-1:0]   r_acc;
    logic [2*HALF-1:0]  num_ext;
    logic [2*HALF-1:0]  recip;
    logic [HALF-1:0]    op_a;
    logic [HALF-1:0]    op_b;
    logic [2*HALF-1:0]  part;
    logic [ACC_W-1:0]   part_sh;
    logic [NUM_W-1:0]   quo;
    logic [63:0]        quo_ext;
    logic [READ_W-1:0]  mag;

    assign num_ext = (2*HALF)'(r_num);
    assign recip   = (r_div == DIV_131) ? RECIP_131 : RECIP_25;

    // Walk the four half-width partial products, one per cycle.
    always_comb begin
        unique case (r_step)
            2'd0: begin
                op_a = num_ext[HALF-1:0];
                op_b = recip[HALF-1:0];
            end
            2'd1: begin
                op_a = num_ext[HALF-1:0];
                op_b = recip[2*HALF-1:HALF];
            end
            2'd2: begin
                op_a = num_ext[2*HALF-1:HALF];
                op_b = recip[HALF-1:0];
            end
            default: begin
                op_a = num_ext[2*HALF-1:HALF];
                op_b = recip[2*HALF-1:HALF];
            end
        endcase
    end

    assign part = op_a * op_b;

    always_comb begin
        unique case (r_step)
            2'd0:    part_sh = ACC_W'(part);
            2'd3:    part_sh = ACC_W'(part) << (2*HALF);
            default: part_sh = ACC_W'(part) << HALF;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= i_div != DIV_ONE;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 2'd1;
            if (r_step == 2'd3) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_div <= i_div;
            r_neg <= i_neg;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + part_sh;
        end
    end

    assign quo     = (r_div == DIV_ONE) ? r_num : r_acc[SHIFT +: NUM_W];
    assign quo_ext = 64'(quo);
    assign mag     = quo_ext[READ_W-1:0];
    assign o_q     = r_neg ? (~mag + 1'b1) : mag;
    assign o_busy  = r_busy;

endmodule

>>> rtl/sfca_store.sv
// Value store and record emitter: merges lane results and streams the record out.
module sfca_store
    import sfca_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_wr                  i_wr [LANES],
    input  logic                 i_start,
    input  logic [4:0]           i_mask,
    input  logic [31:0]          i_stamp,
    output logic                 o_busy,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [CODE_W-1:0]    o_code,
    output logic [READ_W-1:0]    o_reading,
    output logic                 o_last
);

    logic [READ_W-1:0]  r_val [16];
    logic               r_act;
    logic [CODE_W-1:0]  r_cnt;
    logic [CODE_W-1:0]  r_end;
    logic [4:0]         r_mask;
    logic [31:0]        r_stamp;
    logic               r_ovalid;
    logic [CODE_W-1:0]  r_ocode;
    logic [READ_W-1:0]  r_oread;
    logic               r_olast;
    logic [CODE_W-1:0]  n_end;
    logic               here;
    logic [IDX_W-1:0]   rd_idx;
    logic               room;

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            if (i_wr[l].en) begin
                r_val[i_wr[l].idx] <= i_wr[l].value;
            end
        end
    end

    always_comb begin
        priority if (i_mask[BIT_BRIGHT]) n_end = CODE_BRIGHT;
        else if (i_mask[BIT_MOVE])       n_end = CODE_MOVE_END;
        else if (i_mask[BIT_PRES])       n_end = CODE_PRES_END;
        else if (i_mask[BIT_HUM])        n_end = CODE_HUM_END;
        else if (i_mask[BIT_TEMP])       n_end = CODE_TEMP_END;
        else                             n_end = CODE_HEADER;
    end

    always_comb begin
        priority if (r_cnt == CODE_HEADER) here = 1'b1;
        else if (r_cnt <= CODE_TEMP_END)   here = r_mask[BIT_TEMP];
        else if (r_cnt <= CODE_HUM_END)    here = r_mask[BIT_HUM];
        else if (r_cnt <= CODE_PRES_END)   here = r_mask[BIT_PRES];
        else if (r_cnt <= CODE_MOVE_END)   here = r_mask[BIT_MOVE];
        else                               here = r_mask[BIT_BRIGHT];
    end

    assign rd_idx = IDX_W'(r_cnt - 1'b1);
    assign room   = !r_ovalid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_start) begin
                r_act <= 1'b1;
            end else if (r_act && room && here && r_cnt == r_end) begin
                r_act <= 1'b0;
            end
            if (r_act && room && here) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt   <= CODE_HEADER;
            r_end   <= n_end;
            r_mask  <= i_mask;
            r_stamp <= i_stamp;
        end else if (r_act && room) begin
            r_cnt <= r_cnt + 1'b1;
            if (here) begin
                r_ocode <= r_cnt;
                r_olast <= r_cnt == r_end;
                r_oread <= (r_cnt == CODE_HEADER) ? READ_W'(r_stamp) : r_val[rd_idx];
            end
        end
    end

    assign o_busy    = r_act;
    assign o_valid   = r_ovalid;
    assign o_code    = r_ocode;
    assign o_reading = r_oread;
    assign o_last    = r_olast;

endmodule

>>> rtl/sensor_frame_convert_aggregate.sv
// Top level: sensor frame converter with nine conversion lanes and a record emitter.
//
// Takes one raw sensor frame per item, converts its payload words to signed
// fixed point with FRACTION_BITS fraction bits (truncated toward zero), keeps
// the latest values and a present mask per kind, and once every kind named in
// required_mask is present streams a record: a timestamp header (quantity 0)
// then each present value in quantity order, tlast on the final item. Nine
// lanes each convert one value. Divisions by powers of two are shifts;
// a divide by 100 becomes a shift by two and a divide by 25, which like the
// gyro divide by 131 runs as a reciprocal multiply of four partial products.
// A frame holds the input while it converts and is checked; a divide
// (pressure, movement, brightness) waits on the lanes. Completing a record
// also holds the input while the emitter walks each quantity code from the
// header to the last present one (at most 17), stalling when the output
// holds off. A frame whose length does not match its kind, or of unknown
// kind, converts nothing but still runs the record check. Configuration
// writes are taken at any time but meant for idle periods.
module sensor_frame_convert_aggregate
    import sfca_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // byte_count[7:0], stamp[39:8], word_a[55:40] .. word_i[183:168]
    input  logic [183:0]  s_axis_tdata,
    // action[2:0]
    input  logic [2:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // quantity[4:0], reading[52:5], zero fill[55:53]
    output logic [55:0]   m_axis_tdata,
    output logic          m_axis_tlast,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [4:0]    i_cfg_data
);

    localparam int NUM_W = MAG_W + FRACTION_BITS;

    t_state             r_state;
    logic [4:0]         r_req;
    logic [1:0]         r_range;
    logic [4:0]         r_mask;
    logic [4:0]         r_bit;
    logic [31:0]        r_stamp;
    logic               r_cmd_en [LANES];
    logic [IDX_W-1:0]   r_cmd_idx [LANES];

    logic               accept;
    logic [2:0]         action;
    logic [7:0]         byte_count;
    logic [15:0]        w [LANES];
    logic [15:0]        s_mag [LANES];
    logic               c_en [LANES];
    logic               c_neg [LANES];
    logic [NUM_W-1:0]   c_num [LANES];
    t_div               c_div [LANES];
    logic [IDX_W-1:0]   c_idx [LANES];
    logic [4:0]         c_bit;
    logic               lane_busy [LANES];
    logic [READ_W-1:0]  lane_q [LANES];
    logic               any_busy;
    t_wr                wr [LANES];
    logic               emit_start;
    logic               emit_busy;
    logic [CODE_W-1:0]  o_code;
    logic [READ_W-1:0]  o_read;
    logic signed [27:0] hum_t;
    logic [MAG_W-1:0]   hum_mag;

    assign action        = s_axis_tuser;
    assign byte_count    = s_axis_tdata[7:0];
    assign s_axis_tready = r_state == S_IDLE;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign hum_t = 28'(signed'(w[0])) * 28'sd165 - 28'sd2621440;
    assign hum_mag = hum_t < 0 ? MAG_W'(-hum_t) : MAG_W'(hum_t);

    // Split the payload and take each word's magnitude as a signed value.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w[l]     = s_axis_tdata[40 + 16*l +: 16];
            s_mag[l] = w[l][15] ? (~w[l] + 16'd1) : w[l];
        end
    end

    // Build the per-lane scaled numerator, sign, divisor and store slot.
    always_comb begin
        c_bit = '0;
        for (int l = 0; l < LANES; l++) begin
            c_en[l]  = 1'b0;
            c_neg[l] = 1'b0;
            c_num[l] = '0;
            c_div[l] = DIV_ONE;
            c_idx[l] = '0;
        end
        if (action == ACT_TEMP && byte_count == LEN_TEMP) begin
            c_bit[BIT_TEMP] = 1'b1;
            c_en[0] = 1'b1; c_idx[0] = IDX_W'(0);
            c_num[0] = (NUM_W'(w[0] >> 2) << FRACTION_BITS) >> 5;
            c_en[1] = 1'b1; c_idx[1] = IDX_W'(1);
            c_num[1] = (NUM_W'(w[1] >> 2) << FRACTION_BITS) >> 5;
        end else if (action == ACT_HUM && byte_count == LEN_HUM) begin
            c_bit[BIT_HUM] = 1'b1;
            c_en[0] = 1'b1; c_neg[0] = hum_t < 0; c_idx[0] = IDX_W'(3);
            c_num[0] = (NUM_W'(hum_mag) << FRACTION_BITS) >> 16;
            c_en[1] = 1'b1; c_idx[1] = IDX_W'(2);
            c_num[1] = ((NUM_W'(w[1]) * NUM_W'(100)) << FRACTION_BITS) >> 16;
        end else if (action == ACT_PRES && byte_count == LEN_PRES) begin
            // divide by 100: drop two bits of the scale, then divide by 25
            c_bit[BIT_PRES] = 1'b1;
            c_en[0] = 1'b1; c_div[0] = DIV_25; c_idx[0] = IDX_W'(4);
            c_num[0] = NUM_W'({w[2], w[1][15:8]}) << (FRACTION_BITS - 2);
            c_en[1] = 1'b1; c_div[1] = DIV_25; c_idx[1] = IDX_W'(5);
            c_num[1] = NUM_W'({w[1][7:0], w[0]}) << (FRACTION_BITS - 2);
        end else if (action == ACT_MOVE && byte_count == LEN_MOVE) begin
            c_bit[BIT_MOVE] = 1'b1;
            for (int k = 0; k < 3; k++) begin
                // accel from words d-f, gyro from a-c, magnetometer from g-i
                c_en[k] = 1'b1; c_neg[k] = w[3+k][15]; c_idx[k] = IDX_W'(6 + k);
                c_num[k] = (NUM_W'(s_mag[3+k]) << FRACTION_BITS) >> (4'd14 - 4'(r_range));
                c_en[3+k] = 1'b1; c_neg[3+k] = w[k][15]; c_idx[3+k] = IDX_W'(9 + k);
                c_num[3+k] = NUM_W'(s_mag[k]) << FRACTION_BITS;
                c_div[3+k] = DIV_131;
                c_en[6+k] = 1'b1; c_neg[6+k] = w[6+k][15]; c_idx[6+k] = IDX_W'(12 + k);
                c_num[6+k] = NUM_W'(s_mag[6+k]) << FRACTION_BITS;
            end
        end else if (action == ACT_BRIGHT && byte_count == LEN_BRIGHT) begin
            c_bit[BIT_BRIGHT] = 1'b1;
            c_en[0] = 1'b1; c_div[0] = DIV_25; c_idx[0] = IDX_W'(15);
            c_num[0] = (NUM_W'(w[0][11:0]) << w[0][15:12]) << (FRACTION_BITS - 2);
        end
    end

    genvar g;
    generate
        for (g = 0; g < LANES; g++) begin : g_lane
            sfca_lane #(.NUM_W(NUM_W)) u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_start (accept && c_en[g]),
                .i_neg   (c_neg[g]),
                .i_num   (c_num[g]),
                .i_div   (c_div[g]),
                .o_busy  (lane_busy[g]),
                .o_q     (lane_q[g])
            );
        end
    endgenerate

    always_comb begin
        any_busy = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            any_busy = any_busy | lane_busy[l];
            wr[l].en    = r_state == S_CONV && r_cmd_en[l];
            wr[l].idx   = r_cmd_idx[l];
            wr[l].value = lane_q[l];
        end
    end

    // Start a record once every required kind is present.
    assign emit_start = r_state == S_CHECK && (r_mask & r_req) == r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_req   <= 5'd31;
            r_range <= '0;
            r_mask  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_REQUIRED: r_req   <= i_cfg_data;
                    CFG_ACCEL:    r_range <= i_cfg_data[1:0];
                    default:      r_req   <= r_req;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) r_state <= S_CONV;
                end
                S_CONV: begin
                    // hold until every lane has finished, then merge
                    if (!any_busy) begin
                        r_mask  <= r_mask | r_bit;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (emit_start) begin
                        r_mask  <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (!emit_busy) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bit   <= c_bit;
            r_stamp <= s_axis_tdata[39:8];
            for (int l = 0; l < LANES; l++) begin
                r_cmd_en[l]  <= c_en[l];
                r_cmd_idx[l] <= c_idx[l];
            end
        end
    end

    sfca_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_start   (emit_start),
        .i_mask    (r_mask),
        .i_stamp   (r_stamp),
        .o_busy    (emit_busy),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_code    (o_code),
        .o_reading (o_read),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, o_read, o_code};

endmodule

>>> verif/sfca_record_checker.sv
// Checker: predicts the sensor records and compares them with the output stream.
module sfca_record_checker
    import sfca_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    input  logic          s_axis_tready,
    input  logic [183:0]  s_axis_tdata,
    input  logic [2:0]    s_axis_tuser,
    input  logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  logic [55:0]   m_axis_tdata,
    input  logic          m_axis_tlast,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [4:0]    i_cfg_data,
    output int            o_fail_count,
    output int            o_pending
);

    typedef struct {
        logic [CODE_W-1:0] quantity;
        logic [READ_W-1:0] reading;
        logic              last;
    } t_reading;

    t_reading          records_due[$];
    logic [4:0]        need_mask;
    logic [1:0]        accel_scale;
    logic [4:0]        have_mask;
    logic [READ_W-1:0] stored_vals[16];

    function automatic logic [READ_W-1:0] fix_div(bit neg, longint unsigned mag,
                                                  longint unsigned den);
        longint unsigned q;
        q = mag / den;
        if (neg)
            q = ~q + 1;
        return q[READ_W-1:0];
    endfunction

    function automatic logic [READ_W-1:0] word_div(logic [15:0] w, longint unsigned den);
        longint unsigned mag;
        mag = w[15] ? (64'd65536 - w) : w;
        return fix_div(w[15], mag << FRACTION_BITS, den);
    endfunction

    // Convert one frame, update the stored values and queue any record it completes.
    task automatic absorb_frame(logic [2:0] act, logic [7:0] cnt, logic [31:0] stamp,
                                logic [8:0][15:0] w);
        longint signed   hum_n;
        longint unsigned raw_t;
        longint unsigned raw_p;
        longint unsigned accel_den;
        int              order[16];
        int              n;
        t_reading        item;
        n = 0;
        if (act == ACT_TEMP && cnt == LEN_TEMP) begin
            stored_vals[0] = fix_div(0, longint'(w[0] >> 2) << FRACTION_BITS, 32);
            stored_vals[1] = fix_div(0, longint'(w[1] >> 2) << FRACTION_BITS, 32);
            have_mask[BIT_TEMP] = 1'b1;
        end else if (act == ACT_HUM && cnt == LEN_HUM) begin
            hum_n = longint'($signed(w[0])) * 165 - 2621440;
            stored_vals[3] = fix_div(hum_n < 0, (hum_n < 0 ? -hum_n : hum_n) << FRACTION_BITS,
                                     65536);
            stored_vals[2] = fix_div(0, (longint'(w[1]) * 100) << FRACTION_BITS, 65536);
            have_mask[BIT_HUM] = 1'b1;
        end else if (act == ACT_PRES && cnt == LEN_PRES) begin
            raw_t = {w[1][7:0], w[0]};
            raw_p = {w[2], w[1][15:8]};
            stored_vals[4] = fix_div(0, raw_p << FRACTION_BITS, 100);
            stored_vals[5] = fix_div(0, raw_t << FRACTION_BITS, 100);
            have_mask[BIT_PRES] = 1'b1;
        end else if (act == ACT_MOVE && cnt == LEN_MOVE) begin
            accel_den = 16384 >> accel_scale;
            for (int k = 0; k < 3; k++) begin
                stored_vals[6 + k]  = word_div(w[3 + k], accel_den);
                stored_vals[9 + k]  = word_div(w[k], 131);
                stored_vals[12 + k] = word_div(w[6 + k], 1);
            end
            have_mask[BIT_MOVE] = 1'b1;
        end else if (act == ACT_BRIGHT && cnt == LEN_BRIGHT) begin
            stored_vals[15] = fix_div(0, (longint'(w[0][11:0]) << w[0][15:12]) << FRACTION_BITS,
                                      100);
            have_mask[BIT_BRIGHT] = 1'b1;
        end

        if ((have_mask & need_mask) != need_mask)
            return;

        // Fixed emission order: temperature, humidity, pressure, motion, brightness.
        if (have_mask[BIT_TEMP]) begin
            order[n++] = 0; order[n++] = 1;
        end
        if (have_mask[BIT_HUM]) begin
            order[n++] = 2; order[n++] = 3;
        end
        if (have_mask[BIT_PRES]) begin
            order[n++] = 4; order[n++] = 5;
        end
        if (have_mask[BIT_MOVE]) begin
            for (int k = 6; k < 15; k++)
                order[n++] = k;
        end
        if (have_mask[BIT_BRIGHT])
            order[n++] = 15;

        item.quantity = CODE_HEADER;
        item.reading  = {16'd0, stamp};
        item.last     = (n == 0);
        records_due.push_back(item);
        for (int k = 0; k < n; k++) begin
            item.quantity = CODE_W'(order[k] + 1);
            item.reading  = stored_vals[order[k]];
            item.last     = (k == n - 1);
            records_due.push_back(item);
        end
        have_mask = '0;
    endtask

    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            need_mask    = 5'd31;
            accel_scale  = 2'd0;
            have_mask    = '0;
            o_fail_count = 0;
            records_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_REQUIRED)
                    need_mask = i_cfg_data;
                else
                    accel_scale = i_cfg_data[1:0];
            end
            if (s_axis_tvalid && s_axis_tready)
                absorb_frame(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[39:8],
                             s_axis_tdata[183:40]);
            if (m_axis_tvalid && m_axis_tready) begin
                if (records_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result: quantity %0d reading %h last %b",
                                 m_axis_tdata[4:0], m_axis_tdata[52:5], m_axis_tlast);
                end else begin
                    want = records_due.pop_front();
                    if (want.quantity !== m_axis_tdata[4:0] || want.reading !== m_axis_tdata[52:5]
                        || want.last !== m_axis_tlast) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: expected q %0d r %h l %b, got q %0d r %h l %b",
                                     want.quantity, want.reading, want.last,
                                     m_axis_tdata[4:0], m_axis_tdata[52:5], m_axis_tlast);
                    end
                end
            end
        end
        o_pending = records_due.size();
    end

endmodule

>>> verif/sensor_frame_convert_aggregate_test.sv
// Testbench top: drives frames and configuration, applies back-pressure, gives the verdict.
module sensor_frame_convert_aggregate_test
    import sfca_pkg::*;
;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [183:0]  s_axis_tdata = '0;   // byte_count, stamp, word_a .. word_i
    logic [2:0]    s_axis_tuser = '0;   // action
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [55:0]   m_axis_tdata;        // quantity, reading, zero fill
    logic          m_axis_tlast;
    logic          i_cfg_we = 1'b0;
    logic          i_cfg_idx = CFG_REQUIRED;
    logic [4:0]    i_cfg_data = '0;

    int fail_count;
    int pending;
    int tx_idle_pct = 0;    // chance per cycle that the sender holds off
    int rx_stall_pct = 0;   // chance per cycle that the receiver stalls
    int hold_req = 0;       // long receiver hold-off, picked up by the receiver process
    int hold_left = 0;

    always #4 i_clk = ~i_clk;

    sensor_frame_convert_aggregate u_top (.*);

    sfca_record_checker u_check (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: random stalls, or a counted long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Generous upper bound on the run.
    initial begin
        #(8 * 1500000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [15:0] pick_word();
        case ($urandom_range(15))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    // Offer one frame, after a random gap; hold valid until it is taken.
    task automatic send_frame(logic [2:0] act, logic [7:0] cnt, logic [8:0][15:0] w);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {w, 32'($urandom), cnt};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    // Random frame: mostly well formed, some with a wrong length or an unknown kind.
    task automatic send_random_frame();
        logic [8:0][15:0] w;
        logic [2:0]       act;
        logic [7:0]       cnt;
        for (int k = 0; k < 9; k++)
            w[k] = pick_word();
        act = 3'($urandom_range(4));
        case (act)
            ACT_TEMP: cnt = LEN_TEMP;
            ACT_HUM:  cnt = LEN_HUM;
            ACT_PRES: cnt = LEN_PRES;
            ACT_MOVE: cnt = LEN_MOVE;
            default:  cnt = LEN_BRIGHT;
        endcase
        if ($urandom_range(9) == 0) begin
            act = 3'($urandom_range(7));
            cnt = 8'($urandom_range(255));
        end
        send_frame(act, cnt, w);
    endtask

    // Drop valid, wait for every expected result, then let a stray frame finish.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [4:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int req_set[6]   = '{31, 0, 1, 16, 12, 31};
        int accel_set[6] = '{0, 3, 1, 2, 3, 0};
        int tx_set[6]    = '{0, 80, 0, 17, 0, 80};
        int rx_set[6]    = '{0, 0, 80, 17, 0, 80};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // Directed frames at reset configuration: field extremes of every kind.
        send_frame(ACT_TEMP,   LEN_TEMP,   {112'd0, 16'h0000, 16'hFFFF});
        send_frame(ACT_HUM,    LEN_HUM,    {112'd0, 16'hFFFF, 16'h8000});
        send_frame(ACT_PRES,   LEN_PRES,   {96'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_frame(ACT_MOVE,   LEN_MOVE,   {16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000,
                                            16'h7FFF, 16'h0001, 16'h8000, 16'h7FFF,
                                            16'hFFFF});
        send_frame(ACT_BRIGHT, LEN_BRIGHT, {128'd0, 16'hFFFF});
        send_frame(ACT_TEMP,   LEN_TEMP,   {112'd0, 16'hFFFF, 16'h0003});
        send_frame(ACT_HUM,    LEN_HUM,    {112'd0, 16'h0000, 16'h7FFF});
        send_frame(ACT_PRES,   LEN_PRES,   {96'd0, 16'h0000, 16'h0000, 16'h0000});
        // length mismatch and unknown kinds: convert nothing
        send_frame(ACT_TEMP,   8'd5,       {144{1'b1}});
        send_frame(ACT_MOVE,   8'd255,     {144{1'b1}});
        send_frame(3'd5,       LEN_TEMP,   {144{1'b1}});
        send_frame(3'd6,       8'd0,       '0);
        send_frame(3'd7,       LEN_BRIGHT, {144{1'b1}});
        send_frame(ACT_MOVE,   LEN_MOVE,   {9{16'h0000}});
        send_frame(ACT_BRIGHT, LEN_BRIGHT, {128'd0, 16'h0FFF});
        drain();

        // Empty requirement: every frame emits, a lone header when nothing is present.
        write_cfg(CFG_REQUIRED, 5'd0);
        write_cfg(CFG_ACCEL, 5'd3);
        send_frame(3'd5, 8'd0, '0);
        send_frame(ACT_BRIGHT, LEN_BRIGHT, {128'd0, 16'hF001});
        send_frame(ACT_MOVE, LEN_MOVE, {9{16'h8000}});
        drain();

        // Random phases, each with its own configuration and idling pattern.
        for (int ph = 0; ph < 6; ph++) begin
            write_cfg(CFG_REQUIRED, 5'(req_set[ph]));
            write_cfg(CFG_ACCEL, 5'(accel_set[ph]));
            tx_idle_pct  = tx_set[ph];
            rx_stall_pct = rx_set[ph];
            for (int n = 0; n < 70; n++) begin
                // Hold the receiver off long enough to back up the block.
                if (ph == 0 && n == 10)
                    hold_req = 600;
                // Pause the sender until every result is out.
                if (ph == 2 && n == 35)
                    drain();
                send_random_frame();
            end
            drain();
        end

        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
